// ----- rtl/mesi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MESI coherence package
// Line states, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package mesi_pkg;

	localparam logic [1:0] ST_I = 2'd0;
	localparam logic [1:0] ST_S = 2'd1;
	localparam logic [1:0] ST_E = 2'd2;
	localparam logic [1:0] ST_M = 2'd3;

	localparam logic [1:0] REG_SET_INDEX_BITS    = 2'd0;
	localparam logic [1:0] REG_BLOCK_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS_IN_USE       = 2'd2;

	localparam logic [9:0] MISS_CYCLES = 10'd100;

	typedef struct packed {
		logic [1:0]  core;
		logic        cmd;
		logic [31:0] addr;
	} req_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] new_state;
		logic       victim_evicted;
		logic       victim_writeback;
		logic       bus_transaction;
		logic       shared_seen;
		logic       supplied_by_peer;
		logic       supplied_modified;
		logic [1:0] peer_writebacks;
		logic [1:0] peer_invalidations;
		logic [9:0] stall_cycles;
	} rsp_t;

endpackage
`default_nettype wire

// ----- rtl/mesi_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface mesi_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/mesi_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mesi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/mesi_snoopy_cache_system.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// MESI snooping cache system
// Four private set-associative caches kept coherent by snooping, with
// stamp-based LRU replacement. One access in, one result out.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   core, cmd, addr
//  rsp      out  hit, new_state, victim/peer flags, stall_cycles
//  cfg      in   we, idx, wdata
//
// An access is handled in phases: the accepting cycle reads the set row of all
// cores and ways from one wide RAM, the read phase registers that row, and the
// write phase decides, writes the row back and loads the output register. After
// reset the RAM is swept invalid, one row a cycle, with no access taken. A held
// result stalls the next access only in its final phase.
// ----------------------------------------------------------------------------
module mesi_snoopy_cache_system #(
	parameter int CORES    = 4,
	parameter int SET_BITS = 6,
	parameter int WAYS     = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mesi_stream_if.sink     req,
	mesi_stream_if.source   rsp,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [3:0] cfg_wdata
);
	localparam int NSETS  = 1 << SET_BITS;
	localparam int SW     = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int LW     = 30 + 2 + 1 + 32;
	localparam int NL     = CORES * WAYS;
	localparam int RW     = LW * NL;
	localparam int CW     = $clog2(CORES);
	localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NWW    = $clog2(WAYS + 1);
	localparam int PCW    = $clog2(NL + 1);

	typedef struct packed {
		logic [29:0] tag;
		logic [1:0]  st;
		logic        dirty;
		logic [31:0] stamp;
	} line_t;

	localparam logic [1:0] PH_CLR  = 2'd0;
	localparam logic [1:0] PH_IDLE = 2'd1;
	localparam logic [1:0] PH_RD   = 2'd2;
	localparam logic [1:0] PH_WR   = 2'd3;

	logic [1:0]  ph_q;
	logic [SW:0] clr_q;
	logic [2:0]  sib_q;
	logic [3:0]  bob_q;
	logic [2:0]  wiu_q;
	logic [31:0] cnt_q [CORES];
	mesi_pkg::req_t req_q;
	logic [SW-1:0] set_q;
	logic [29:0]   tag_q;
	logic [3:0]    bobe_q;
	logic [NWW-1:0] nw_q;
	logic          bad_q;
	logic [RW-1:0] row_new;
	mesi_pkg::rsp_t res_c, out_q;
	logic          oval_q;

	logic          ram_we;
	logic [SW-1:0] ram_wa, ram_ra;
	logic [RW-1:0] ram_wd, ram_rd;

	// Effective configuration.
	logic [2:0] sib_e;
	logic [3:0] bob_e;
	logic [NWW-1:0] nw_e;
	always_comb begin
		sib_e = (32'(sib_q) > 32'(SET_BITS)) ? 3'(SET_BITS) : sib_q;
		bob_e = (bob_q < 4'd2) ? 4'd2 : ((bob_q > 4'd10) ? 4'd10 : bob_q);
		if (wiu_q == 3'd0) nw_e = NWW'(1);
		else if (32'(wiu_q) > 32'(WAYS)) nw_e = NWW'(WAYS);
		else nw_e = NWW'(wiu_q);
	end

	logic [31:0] a_set;
	logic [31:0] a_tag;
	always_comb begin
		a_set = (req.data.addr >> bob_e) & ((32'd1 << sib_e) - 32'd1);
		a_tag = req.data.addr >> (6'(sib_e) + 6'(bob_e));
	end

	assign req.ready = (ph_q == PH_IDLE);
	wire acc = req.valid && req.ready;
	wire fin = (ph_q == PH_WR) && (!oval_q || rsp.ready);

	assign ram_ra = acc ? SW'(a_set) : set_q;
	assign ram_we = (ph_q == PH_CLR) || fin;
	assign ram_wa = (ph_q == PH_CLR) ? clr_q[SW-1:0] : set_q;
	assign ram_wd = (ph_q == PH_CLR) ? '0 : row_new;

	mesi_ram #(.WIDTH(RW), .DEPTH(NSETS)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
		.raddr(ram_ra), .rdata(ram_rd)
	);

	// Decision on the row read for the held access.
	logic [RW-1:0] row_rd_s2;
	logic [CW-1:0] rc;
	always_comb begin
		line_t ln, nl;
		logic found, inv_found, shared, sup, supm, snoop, wr;
		logic [WW-1:0] vic;
		logic [PCW-1:0] pwb, pinv;
		logic [31:0] nc, best;
		row_new = row_rd_s2;
		res_c = '0;
		rc = CW'(req_q.core);
		wr = req_q.cmd;
		found = 1'b0; inv_found = 1'b0; vic = '0;
		shared = 1'b0; sup = 1'b0; supm = 1'b0; pwb = '0; pinv = '0;
		nc = cnt_q[rc] + 32'd1;
		best = '0;
		for (int w = 0; w < WAYS; w++) begin
			ln = row_rd_s2[(int'(rc) * WAYS + w) * LW +: LW];
			if (w < int'(nw_q) && !found && ln.st != mesi_pkg::ST_I && ln.tag == tag_q) begin
				found = 1'b1;
				vic = WW'(w);
			end
		end
		if (!found) begin
			for (int w = 0; w < WAYS; w++) begin
				ln = row_rd_s2[(int'(rc) * WAYS + w) * LW +: LW];
				if (w < int'(nw_q) && !inv_found && ln.st == mesi_pkg::ST_I) begin
					inv_found = 1'b1;
					vic = WW'(w);
				end
			end
			if (!inv_found) begin
				ln = row_rd_s2[int'(rc) * WAYS * LW +: LW];
				best = ln.stamp;
				for (int w = 1; w < WAYS; w++) begin
					ln = row_rd_s2[(int'(rc) * WAYS + w) * LW +: LW];
					if (w < int'(nw_q) && ln.stamp < best) begin
						best = ln.stamp;
						vic = WW'(w);
					end
				end
			end
		end
		ln = row_rd_s2[(int'(rc) * WAYS + int'(vic)) * LW +: LW];
		snoop = !found || (wr && ln.st == mesi_pkg::ST_S);
		if (snoop) begin
			for (int p = 0; p < CORES; p++) begin
				for (int w = 0; w < WAYS; w++) begin
					nl = row_rd_s2[(p * WAYS + w) * LW +: LW];
					if (p != int'(rc) && w < int'(nw_q) && nl.st != mesi_pkg::ST_I
							&& nl.tag == tag_q) begin
						if (wr) begin
							if (nl.st == mesi_pkg::ST_M) pwb = pwb + PCW'(1);
							pinv = pinv + PCW'(1);
							nl.st = mesi_pkg::ST_I;
							nl.dirty = 1'b0;
						end else if (nl.st == mesi_pkg::ST_M) begin
							sup = 1'b1; supm = 1'b1; shared = 1'b1;
							pwb = pwb + PCW'(1);
							nl.st = mesi_pkg::ST_S;
						end else if (nl.st == mesi_pkg::ST_E) begin
							sup = 1'b1; shared = 1'b1;
							nl.st = mesi_pkg::ST_S;
						end else begin
							shared = 1'b1;
						end
						row_new[(p * WAYS + w) * LW +: LW] = nl;
					end
				end
			end
		end
		nl = ln;
		nl.stamp = nc;
		res_c.bus_transaction = snoop;
		if (found) begin
			res_c.hit = 1'b1;
			if (wr) begin
				nl.st = mesi_pkg::ST_M;
				nl.dirty = 1'b1;
			end
			res_c.new_state = nl.st;
		end else begin
			res_c.stall_cycles = mesi_pkg::MISS_CYCLES;
			if (ln.st != mesi_pkg::ST_I) begin
				res_c.victim_evicted = 1'b1;
				if (ln.dirty) begin
					res_c.victim_writeback = 1'b1;
					res_c.stall_cycles = res_c.stall_cycles + mesi_pkg::MISS_CYCLES;
				end
			end
			nl.tag = tag_q;
			nl.st = wr ? mesi_pkg::ST_M : (shared ? mesi_pkg::ST_S : mesi_pkg::ST_E);
			nl.dirty = wr;
			res_c.new_state = nl.st;
			if (sup) res_c.stall_cycles = res_c.stall_cycles + 10'((11'd1 << bobe_q) >> 1);
		end
		row_new[(int'(rc) * WAYS + int'(vic)) * LW +: LW] = nl;
		res_c.shared_seen = shared;
		res_c.supplied_by_peer = sup;
		res_c.supplied_modified = supm;
		res_c.peer_writebacks = (pwb > PCW'(3)) ? 2'd3 : pwb[1:0];
		res_c.peer_invalidations = (pinv > PCW'(3)) ? 2'd3 : pinv[1:0];
		if (bad_q) begin
			res_c = '0;
			row_new = row_rd_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_RD) row_rd_s2 <= ram_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_CLR;
			clr_q <= '0;
			sib_q <= 3'd6;
			bob_q <= 4'd5;
			wiu_q <= 3'd4;
			oval_q <= 1'b0;
			for (int c = 0; c < CORES; c++) cnt_q[c] <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					mesi_pkg::REG_SET_INDEX_BITS:    sib_q <= cfg_wdata[2:0];
					mesi_pkg::REG_BLOCK_OFFSET_BITS: bob_q <= cfg_wdata;
					mesi_pkg::REG_WAYS_IN_USE:       wiu_q <= cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (fin) oval_q <= 1'b1;
			else if (rsp.valid && rsp.ready) oval_q <= 1'b0;
			unique case (ph_q)
				PH_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == NSETS - 1) ph_q <= PH_IDLE;
				end
				PH_IDLE: if (acc) ph_q <= PH_RD;
				PH_RD:   ph_q <= PH_WR;
				PH_WR: if (fin) begin
					ph_q <= PH_IDLE;
					if (!bad_q) cnt_q[rc] <= cnt_q[rc] + 32'd1;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			req_q <= req.data;
			set_q <= SW'(a_set);
			tag_q <= a_tag[29:0];
			bobe_q <= bob_e;
			nw_q <= nw_e;
			bad_q <= (32'(req.data.core) >= CORES);
		end
		if (fin) out_q <= res_c;
	end

	assign rsp.valid = oval_q;
	assign rsp.data = out_q;

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q == PH_RD |=> ph_q == PH_WR) else $error("read not followed by decide");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != PH_IDLE |-> !req.ready) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		oval_q && !rsp.ready |=> oval_q) else $error("result dropped");
endmodule
`default_nettype wire
